// File: design/assert_macros.svh
// assertion macros shared by the decoder modules
// expects clk_i and rst_ni in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define OPWFD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("opwfd assertion failed");

// expression must never be true outside reset
`define OPWFD_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("opwfd forbidden condition seen");

`endif

// File: design/opwfd_pkg.sv
// types and constants of the ook pulse width frame decoder
// used by every module of the block, depends on nothing
`default_nettype none

package opwfd_pkg;

  localparam int unsigned UnitW       = 12;
  localparam int unsigned DurW        = 16;
  localparam int unsigned CmpW        = DurW + 1;
  localparam int unsigned PcountW     = 7;
  localparam int unsigned BcountW     = 6;
  localparam int unsigned ShiftBits   = 36;
  localparam int unsigned StatusW     = 3;
  localparam int unsigned IdW         = 8;
  localparam int unsigned ChanW       = 2;
  localparam int unsigned TempW       = 12;
  localparam int unsigned HumW        = 8;

  localparam logic [UnitW-1:0] UnitReset = 12'd250;

  localparam int unsigned FramePulsesDefault = 74;
  localparam int unsigned MinBitsDefault     = 36;
  localparam int unsigned QueueDepthDefault  = 2;

  typedef enum logic [1:0] {
    CLS_BIT0,
    CLS_BIT1,
    CLS_GAP,
    CLS_BAD
  } cls_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_NO_SYNC   = 3'd1,
    ST_BAD_COUNT = 3'd2,
    ST_BAD_PULSE = 3'd3,
    ST_FEW_BITS  = 3'd4
  } status_e;

  typedef struct packed {
    logic first;
    logic last;
    logic sync_ok;
    cls_e cls;
  } pulse_t;

endpackage

`default_nettype wire

// File: design/opwfd_front.sv
// front end: unit register and per-pulse classification against the unit windows
// depends on opwfd_pkg
`default_nettype none

module opwfd_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [opwfd_pkg::UnitW-1:0] cfg_wdata_i,
  input  wire logic                        pulse_level_i,
  input  wire logic [opwfd_pkg::DurW-1:0]  duration_us_i,
  input  wire logic                        first_pulse_i,
  input  wire logic                        last_pulse_i,
  output opwfd_pkg::pulse_t                pulse_o
);
  import opwfd_pkg::*;

  logic [UnitW-1:0] unit_q, unit_d;
  logic [CmpW-1:0]  u1, u3, u5, u7, u9, half_u, dur, dur2;
  logic             is_bit0, is_bit1, is_gap;

  always_comb begin
    unit_d = cfg_we_i ? cfg_wdata_i : unit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= UnitReset;
    end else begin
      unit_q <= unit_d;
    end
  end

  // window edges, all fit in 17 bits for a 12-bit unit
  always_comb begin
    u1     = CmpW'(unit_q);
    u3     = (u1 << 1) + u1;
    u5     = (u1 << 2) + u1;
    u7     = (u1 << 3) - u1;
    u9     = (u1 << 3) + u1;
    half_u = CmpW'(unit_q[UnitW-1:1]);
    dur    = CmpW'(duration_us_i);
    dur2   = {duration_us_i, 1'b0};

    is_bit0 = pulse_level_i && (dur > u1) && (dur < u3);
    is_bit1 = pulse_level_i && (dur > u3) && (dur < u5);
    is_gap  = !pulse_level_i && (dur > half_u) && (dur2 < u3);

    pulse_o.first   = first_pulse_i;
    pulse_o.last    = last_pulse_i;
    pulse_o.sync_ok = pulse_level_i && (dur > u7) && (dur < u9);
    if (is_bit0) begin
      pulse_o.cls = CLS_BIT0;
    end else if (is_bit1) begin
      pulse_o.cls = CLS_BIT1;
    end else if (is_gap) begin
      pulse_o.cls = CLS_GAP;
    end else begin
      pulse_o.cls = CLS_BAD;
    end
  end

endmodule

`default_nettype wire

// File: design/opwfd_queue.sv
// short queue of classified pulses between front and back end
// depends on opwfd_pkg and assert_macros.svh
`default_nettype none

module opwfd_queue #(
  parameter int unsigned Depth = opwfd_pkg::QueueDepthDefault
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire opwfd_pkg::pulse_t push_data_i,
  output logic          ready_o,
  output logic          valid_o,
  output opwfd_pkg::pulse_t pop_data_o,
  input  wire logic     pop_i
);
  import opwfd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pulse_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  always_comb begin
    ready_o    = (count_q < CntW'(Depth));
    valid_o    = (count_q != '0);
    pop_data_o = mem_q[rd_ptr_q];
    do_push    = push_i && ready_o;
    do_pop     = pop_i && valid_o;

    wr_ptr_d = wr_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    rd_ptr_d = rd_ptr_q;
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`include "assert_macros.svh"

  `OPWFD_NEVER(a_count_bound, count_q > CntW'(Depth))
  `OPWFD_ASSERT(a_count_track, (do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)

endmodule

`default_nettype wire

// File: design/opwfd_back.sv
// back end: frame state, bit shifting, status and field unpacking, result register
// depends on opwfd_pkg and assert_macros.svh
`default_nettype none

module opwfd_back #(
  parameter int unsigned FramePulses = opwfd_pkg::FramePulsesDefault,
  parameter int unsigned MinBits     = opwfd_pkg::MinBitsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire opwfd_pkg::pulse_t             pulse_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [opwfd_pkg::StatusW-1:0]      status_o,
  output logic [opwfd_pkg::IdW-1:0]          sensor_id_o,
  output logic                               battery_flag_o,
  output logic [opwfd_pkg::ChanW-1:0]        channel_number_o,
  output logic signed [opwfd_pkg::TempW-1:0] temperature_o,
  output logic [opwfd_pkg::HumW-1:0]         humidity_o
);
  import opwfd_pkg::*;

  logic [PcountW-1:0]   pcount_q, pcount_d, pcount_n;
  logic [BcountW-1:0]   bcount_q, bcount_d, bcount_n;
  logic [ShiftBits-1:0] shreg_q, shreg_d, shreg_n;
  logic                 sync_q, sync_d, sync_n;
  logic                 err_q, err_d, err_n;
  logic                 out_valid_q, out_valid_d;
  status_e              status_q, status_d;
  logic [IdW-1:0]       id_q, id_d;
  logic                 batt_q, batt_d;
  logic [ChanW-1:0]     chan_q, chan_d;
  logic [TempW-1:0]     temp_q, temp_d;
  logic [HumW-1:0]      hum_q, hum_d;
  logic                 new_frame, take_result;

  always_comb begin
    pop_o       = valid_i && (!pulse_i.last || !out_valid_q || out_ready_i);
    take_result = pop_o && pulse_i.last;
    new_frame   = pulse_i.first || (pcount_q == '0);

    pcount_n = pcount_q;
    bcount_n = bcount_q;
    shreg_n  = shreg_q;
    sync_n   = sync_q;
    err_n    = err_q;
    if (new_frame) begin
      bcount_n = '0;
      shreg_n  = '0;
      sync_n   = pulse_i.sync_ok;
      err_n    = 1'b0;
      pcount_n = '0;
    end else begin
      case (pulse_i.cls)
        CLS_BIT0, CLS_BIT1: begin
          if (bcount_q < BcountW'(ShiftBits)) begin
            shreg_n = {shreg_q[ShiftBits-2:0], (pulse_i.cls == CLS_BIT1)};
          end
          if (bcount_q != '1) begin
            bcount_n = bcount_q + 1'b1;
          end
        end
        CLS_GAP: begin
        end
        CLS_BAD: begin
          err_n = 1'b1;
        end
        default: begin
          err_n = 1'b1;
        end
      endcase
    end
    if (pcount_n != '1) begin
      pcount_n = pcount_n + 1'b1;
    end

    // status in priority order
    if (!sync_n) begin
      status_d = ST_NO_SYNC;
    end else if (pcount_n != PcountW'(FramePulses)) begin
      status_d = ST_BAD_COUNT;
    end else if (err_n) begin
      status_d = ST_BAD_PULSE;
    end else if (bcount_n < BcountW'(MinBits)) begin
      status_d = ST_FEW_BITS;
    end else begin
      status_d = ST_OK;
    end

    id_d   = '0;
    batt_d = 1'b0;
    chan_d = '0;
    temp_d = '0;
    hum_d  = '0;
    if (status_d == ST_OK) begin
      id_d   = shreg_n[35:28];
      batt_d = shreg_n[27];
      chan_d = shreg_n[25:24];
      temp_d = shreg_n[23:12];
      hum_d  = shreg_n[7:0];
    end

    pcount_d = pcount_q;
    bcount_d = bcount_q;
    shreg_d  = shreg_q;
    sync_d   = sync_q;
    err_d    = err_q;
    if (take_result) begin
      pcount_d = '0;
      bcount_d = '0;
      shreg_d  = '0;
      sync_d   = 1'b0;
      err_d    = 1'b0;
    end else if (pop_o) begin
      pcount_d = pcount_n;
      bcount_d = bcount_n;
      shreg_d  = shreg_n;
      sync_d   = sync_n;
      err_d    = err_n;
    end

    if (take_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q    <= '0;
      bcount_q    <= '0;
      shreg_q     <= '0;
      sync_q      <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pcount_q    <= pcount_d;
      bcount_q    <= bcount_d;
      shreg_q     <= shreg_d;
      sync_q      <= sync_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (take_result) begin
      status_q <= status_d;
      id_q     <= id_d;
      batt_q   <= batt_d;
      chan_q   <= chan_d;
      temp_q   <= temp_d;
      hum_q    <= hum_d;
    end
  end

  always_comb begin
    out_valid_o      = out_valid_q;
    status_o         = status_q;
    sensor_id_o      = id_q;
    battery_flag_o   = batt_q;
    channel_number_o = chan_q;
    temperature_o    = signed'(temp_q);
    humidity_o       = hum_q;
  end

`include "assert_macros.svh"

  `OPWFD_ASSERT(a_fail_fields_zero, (out_valid_q && status_q != ST_OK) |->
    (id_q == '0 && !batt_q && chan_q == '0 && temp_q == '0 && hum_q == '0))
  `OPWFD_ASSERT(a_closed_frame_clear, (pcount_q == '0) |->
    (bcount_q == '0 && shreg_q == '0 && !sync_q && !err_q))

endmodule

`default_nettype wire

// File: design/ook_pulse_width_frame_decoder.sv
// top level of the ook pulse width frame decoder
// instantiates opwfd_front, opwfd_queue and opwfd_back, depends on opwfd_pkg
//
// input channel: one timed pulse per transfer (level, duration, first and last marks)
// output channel: one result per burst, sent on the transfer of the pulse marked last
// configuration: pulse_unit_us written through cfg_we_i / cfg_wdata_i, reset 250,
//   write only while no pulse is in flight
// the front classifies a pulse in the cycle of its transfer and writes it into a
//   short queue; the back end pops one pulse per cycle and updates the frame state
// throughput: one pulse per cycle, unless a last pulse waits on a stalled receiver
// the result of a last pulse is registered when the back end pops it
// a stalled receiver holds the result register; the back end keeps consuming pulses
//   that are not marked last, and the queue fills only when a second result waits
// reset clears the unit to 250, empties the queue, closes any open frame and drops
//   a pending result
`default_nettype none

module ook_pulse_width_frame_decoder #(
  parameter int unsigned FramePulses = opwfd_pkg::FramePulsesDefault,
  parameter int unsigned MinBits     = opwfd_pkg::MinBitsDefault,
  parameter int unsigned QueueDepth  = opwfd_pkg::QueueDepthDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [opwfd_pkg::UnitW-1:0]   cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          pulse_level_i,
  input  wire logic [opwfd_pkg::DurW-1:0]    duration_us_i,
  input  wire logic                          first_pulse_i,
  input  wire logic                          last_pulse_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [opwfd_pkg::StatusW-1:0]      status_o,
  output logic [opwfd_pkg::IdW-1:0]          sensor_id_o,
  output logic                               battery_flag_o,
  output logic [opwfd_pkg::ChanW-1:0]        channel_number_o,
  output logic signed [opwfd_pkg::TempW-1:0] temperature_o,
  output logic [opwfd_pkg::HumW-1:0]         humidity_o
);
  import opwfd_pkg::*;

  pulse_t front_pulse, queue_pulse;
  logic   queue_valid, queue_pop;

  opwfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pulse_level_i (pulse_level_i),
    .duration_us_i (duration_us_i),
    .first_pulse_i (first_pulse_i),
    .last_pulse_i  (last_pulse_i),
    .pulse_o       (front_pulse)
  );

  opwfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_pulse),
    .ready_o     (in_ready_o),
    .valid_o     (queue_valid),
    .pop_data_o  (queue_pulse),
    .pop_i       (queue_pop)
  );

  opwfd_back #(
    .FramePulses (FramePulses),
    .MinBits     (MinBits)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (queue_valid),
    .pulse_i          (queue_pulse),
    .pop_o            (queue_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .sensor_id_o      (sensor_id_o),
    .battery_flag_o   (battery_flag_o),
    .channel_number_o (channel_number_o),
    .temperature_o    (temperature_o),
    .humidity_o       (humidity_o)
  );

endmodule

`default_nettype wire
